// ===== rtl/core/mwo_pkg.sv =====
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared constants, waveform codes and sine table generation for the
// multi-waveform oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

  localparam int unsigned H_BITS      = 48;
  localparam int unsigned WAVE_BITS   = 3;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned STEP_BITS   = 32;
  localparam int unsigned MAG_BITS    = 15;

  localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd0;
  localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd2;
  localparam logic [WAVE_BITS-1:0] WAVE_SAW_DOWN = 3'd3;
  localparam logic [WAVE_BITS-1:0] WAVE_SAW_UP   = 3'd4;

  localparam logic [H_BITS-1:0] H_HALF = H_BITS'(1) << (H_BITS - 1);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX  = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN  = -16'sh8000;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_ZERO = 16'sh0000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Quarter-wave sine magnitude in Q15, Taylor series to the fifteenth power
  function automatic logic [MAG_BITS-1:0] sine_quarter(input logic [63:0] m,
                                                       input int unsigned tbl_bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] v;
    x    = (m * HALF_PI_Q30) >> (tbl_bits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[MAG_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/mwo_shaper.sv =====
// ----------------------------------------------------------------------------
// mwo_shaper
// Maps a phase value to a Q1.15 sample of the selected waveform.
// ----------------------------------------------------------------------------
module mwo_shaper
  import mwo_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic [PHASE_BITS-1:0]         phase_i,
  input  logic [WAVE_BITS-1:0]          waveform_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  localparam int unsigned QW      = SINE_TABLE_BITS - 2;
  localparam int unsigned QUARTER = 1 << QW;

  typedef logic [MAG_BITS-1:0] sine_lut_t [QUARTER];

  function automatic sine_lut_t build_lut();
    sine_lut_t lut;
    for (int unsigned i = 0; i < QUARTER; i++) begin
      lut[i] = sine_quarter(64'(i), SINE_TABLE_BITS);
    end
    return lut;
  endfunction

  localparam sine_lut_t           SINE_LUT  = build_lut();
  localparam logic [MAG_BITS-1:0] SINE_PEAK = sine_quarter(64'(QUARTER), SINE_TABLE_BITS);

  logic [H_BITS-1:0]             h;
  logic [1:0]                    quad;
  logic [QW-1:0]                 r;
  logic [QW-1:0]                 r_neg;
  logic [MAG_BITS-1:0]           s_mag;
  logic signed [SAMPLE_BITS-1:0] sine_val;
  logic [H_BITS-1:0]             d;
  logic [16:0]                   tri_t;
  logic [15:0]                   u;
  logic [16:0]                   down_diff;

  assign h     = H_BITS'(phase_i) << (H_BITS - PHASE_BITS);
  assign quad  = h[H_BITS-1 -: 2];
  assign r     = h[H_BITS-3 -: QW];
  assign r_neg = -r;

  always_comb begin
    if (quad[0] && (r == '0)) begin
      s_mag = SINE_PEAK;
    end else if (quad[0]) begin
      s_mag = SINE_LUT[r_neg];
    end else begin
      s_mag = SINE_LUT[r];
    end
  end

  assign sine_val = quad[1] ? -signed'({1'b0, s_mag}) : signed'({1'b0, s_mag});

  assign d         = h[H_BITS-1] ? {1'b0, h[H_BITS-2:0]} : (H_HALF - h);
  assign tri_t     = d[H_BITS-1 -: 17];
  assign u         = h[H_BITS-1 -: 16];
  assign down_diff = 17'd32768 - {1'b0, u};

  always_comb begin
    case (waveform_i)
      WAVE_SINE: begin
        sample_o = sine_val;
      end
      WAVE_TRIANGLE: begin
        sample_o = tri_t[16] ? SAMPLE_MAX : signed'({~tri_t[15], tri_t[14:0]});
      end
      WAVE_SQUARE: begin
        sample_o = (h <= H_HALF) ? SAMPLE_MAX : SAMPLE_MIN;
      end
      WAVE_SAW_DOWN: begin
        sample_o = (u == '0) ? SAMPLE_MAX : signed'(down_diff[15:0]);
      end
      WAVE_SAW_UP: begin
        sample_o = signed'({~u[15], u[14:0]});
      end
      default: begin
        sample_o = SAMPLE_ZERO;
      end
    endcase
  end

endmodule

// ===== rtl/core/multi_waveform_oscillator.sv =====
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// Phase-accumulator oscillator with sine, triangle, square and saw outputs.
// ----------------------------------------------------------------------------
// Pipeline: a taken item's phase is registered in a_phase_q, its sample in
// sample_q. Throughput: one item per cycle unless out_stall_i backs up; the
// phase add and the table lookup before sample_q are combinational.
// Reset: asynchronous, active low; clears the phase, waveform select and
// valid flags. No clearing pass.
module multi_waveform_oscillator
  import mwo_pkg::*;
#(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [WAVE_BITS-1:0]          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [STEP_BITS-1:0]   phase_step_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  logic [WAVE_BITS-1:0]          wave_q;
  logic [PHASE_BITS-1:0]         phase_q;
  logic [PHASE_BITS-1:0]         phase_d;
  logic signed [PHASE_BITS-1:0]  step_ext;
  logic                          a_valid_q;
  logic [PHASE_BITS-1:0]         a_phase_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] shaped;
  logic                          in_acc;
  logic                          b_ready;

  assign b_ready    = !out_valid_q || !out_stall_i;
  assign in_stall_o = a_valid_q && !b_ready;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign step_ext   = PHASE_BITS'(phase_step_i);
  assign phase_d    = phase_q + step_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= WAVE_SINE;
    end else if (cfg_we_i) begin
      wave_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      a_valid_q <= 1'b0;
    end else if (in_acc) begin
      phase_q   <= phase_d;
      a_valid_q <= 1'b1;
    end else if (b_ready) begin
      a_valid_q <= 1'b0;
    end
  end

  // hold the phase seen by the item being shaped
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_phase_q <= phase_q;
    end
  end

  mwo_shaper #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_shaper (
    .phase_i    (a_phase_q),
    .waveform_i (wave_q),
    .sample_o   (shaped)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_ready) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && a_valid_q) begin
      sample_q <= shaped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

`ifndef SYNTHESIS
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(phase_q))
    else $error("phase changed without an item");

  a_phase_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> phase_q == $past(phase_d))
    else $error("phase did not advance by the step");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input taken while the pipeline is full");

  a_square_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_ready && a_valid_q && wave_q == WAVE_SQUARE)
    |=> (sample_q == SAMPLE_MAX || sample_q == SAMPLE_MIN))
    else $error("square sample not at full scale");
`endif

endmodule
